// ----- rtl/rrcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rrcw_pkg;

	// Window format: unsigned fixed point, whole packets above FRAC_BITS fraction bits.
	localparam int FRAC_BITS = 8;
	localparam int PKT_W     = 16;
	localparam int WIN_W     = PKT_W + FRAC_BITS;
	localparam int RTO_W     = 13;
	localparam int SRTT_W    = 24;
	localparam int RVAR_W    = 20;
	localparam int RETRY_W   = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	// Widest intermediate RTO sum: srtt + variance + pad.
	localparam int RTO_SUM_W = 22;

	localparam logic [RTO_W-1:0] RTO_MAX = RTO_W'(5000);
	localparam logic [RTO_W-1:0] RTO_MIN = RTO_W'(1000);
	localparam logic [RTO_SUM_W-1:0] RTO_PAD = RTO_SUM_W'(10);

	localparam logic [WIN_W-1:0] ONE_PKT = WIN_W'(1) << FRAC_BITS;
	localparam logic [WIN_W-1:0] TWO_PKT = WIN_W'(2) << FRAC_BITS;

	localparam logic [PKT_W-1:0]   INITIAL_WINDOW_RST = PKT_W'(2);
	localparam logic [PKT_W-1:0]   WINDOW_LIMIT_RST   = PKT_W'(64);
	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST    = RETRY_W'(3);

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_TIMEOUT = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_WINDOW = 2'd0,
		REG_WINDOW_LIMIT   = 2'd1,
		REG_RETRY_LIMIT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        rtt_sample_ms;
		logic               sample_valid;
		logic [PKT_W-1:0]   receiver_window;
		logic               window_cut_allowed;
		logic [RETRY_W-1:0] transmit_count;
	} item_t;

	typedef struct packed {
		logic [RTO_W-1:0] rto_ms;
		logic [WIN_W-1:0] cwnd_q8;
		logic [WIN_W-1:0] ssthresh_q8;
		logic [PKT_W-1:0] send_limit;
		logic             give_up;
	} result_t;

	// Packets to fixed point; a 16-bit count always fits the 24-bit field.
	function automatic logic [WIN_W-1:0] to_q(input logic [PKT_W-1:0] pkts);
		to_q = {pkts, FRAC_BITS'(0)};
	endfunction

	function automatic logic [RTO_W-1:0] clamp_rto(input logic [RTO_SUM_W-1:0] r);
		if (r > RTO_SUM_W'(RTO_MAX)) begin
			clamp_rto = RTO_MAX;
		end else if (r < RTO_SUM_W'(RTO_MIN)) begin
			clamp_rto = RTO_MIN;
		end else begin
			clamp_rto = r[RTO_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/rrcw_item_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rrcw_item_if import rrcw_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rrcw_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rrcw_result_if import rrcw_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/rtt_rto_congestion_window.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// item      in         kind, RTT sample, sample flag, receiver window, cut flag, tx count
// result    out        RTO, cwnd, ssthresh, send limit, give-up flag
// wr_*      in         register write: enable, index, data (no read-back)
//
// Every item yields exactly one result beat: the item is held in the stage-one
// register, then the state update loads the result register. With the result
// side ready, one item is taken every cycle. While a result beat waits, stage
// one still takes one more item and then holds it, which stalls the input.
// Reset loads the windows from the register reset values and sets the RTO to
// 5000 ms.
module rtt_rto_congestion_window
	import rrcw_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rrcw_item_if.sink                 item,
	rrcw_result_if.source             result,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data
);

	// Configuration registers.
	logic [PKT_W-1:0]   initial_window_q;
	logic [PKT_W-1:0]   window_limit_q;
	logic [RETRY_W-1:0] retry_limit_q;

	// Estimator and window state.
	logic               has_estimate_q;
	logic [SRTT_W-1:0]  srtt_x8_q;
	logic [RVAR_W-1:0]  rvar_x4_q;
	logic [RTO_W-1:0]   rto_q;
	logic [WIN_W-1:0]   cwnd_q;
	logic [WIN_W-1:0]   ssthresh_q;
	logic [PKT_W-1:0]   peer_window_q;

	// Pipeline.
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_data_q;
	logic    advance;

	// Next-state values.
	logic               has_estimate_d;
	logic [SRTT_W-1:0]  srtt_x8_d;
	logic [RVAR_W-1:0]  rvar_x4_d;
	logic [RTO_W-1:0]   rto_d;
	logic [WIN_W-1:0]   cwnd_d;
	logic [WIN_W-1:0]   ssthresh_d;
	logic [PKT_W-1:0]   peer_window_d;
	logic               give_up_d;
	logic [PKT_W-1:0]   send_limit_d;

	// Datapath intermediates.
	logic [20:0]        srtt_whole;
	logic [20:0]        sample_ext;
	logic [20:0]        dev_abs;
	logic [SRTT_W:0]    srtt_sum;
	logic [21:0]        rvar_sum;
	logic [WIN_W:0]     cwnd_grown;
	logic [WIN_W:0]     cwnd_cap;
	logic [WIN_W-1:0]   cwnd_half;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready   = !valid_s1 || advance;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_window_q <= INITIAL_WINDOW_RST;
			window_limit_q   <= WINDOW_LIMIT_RST;
			retry_limit_q    <= RETRY_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_INITIAL_WINDOW: initial_window_q <= wr_data[PKT_W-1:0];
				REG_WINDOW_LIMIT:   window_limit_q   <= wr_data[PKT_W-1:0];
				REG_RETRY_LIMIT:    retry_limit_q    <= wr_data[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	// Work out the state after the item in stage one.
	always_comb begin
		has_estimate_d = has_estimate_q;
		srtt_x8_d      = srtt_x8_q;
		rvar_x4_d      = rvar_x4_q;
		rto_d          = rto_q;
		cwnd_d         = cwnd_q;
		ssthresh_d     = ssthresh_q;
		peer_window_d  = peer_window_q;
		give_up_d      = 1'b0;

		// Error between the sample and the current smoothed RTT.
		srtt_whole = srtt_x8_q[SRTT_W-1:3];
		sample_ext = 21'(item_s1.rtt_sample_ms);
		dev_abs    = (sample_ext >= srtt_whole) ? (sample_ext - srtt_whole)
		                                        : (srtt_whole - sample_ext);
		// srtt += err / 8, variance += (|err| - variance) / 4, both kept scaled.
		srtt_sum   = (SRTT_W+1)'(srtt_x8_q) - (SRTT_W+1)'(srtt_whole)
		             + (SRTT_W+1)'(item_s1.rtt_sample_ms);
		rvar_sum   = 22'(rvar_x4_q) - 22'(rvar_x4_q[RVAR_W-1:2]) + 22'(dev_abs);

		// Slow start doubles the window, congestion avoidance adds one packet.
		cwnd_grown = (cwnd_q < ssthresh_q) ? {cwnd_q, 1'b0}
		                                   : ((WIN_W+1)'(cwnd_q) + (WIN_W+1)'(ONE_PKT));
		cwnd_cap   = (WIN_W+1)'(to_q(window_limit_q));
		cwnd_half  = cwnd_q >> 1;

		case (item_s1.kind)
			KIND_ACK: begin
				peer_window_d = item_s1.receiver_window;
				if (item_s1.sample_valid) begin
					has_estimate_d = 1'b1;
					if (!has_estimate_q) begin
						// First sample seeds srtt with no variance; RTO is four samples plus the pad.
						srtt_x8_d = SRTT_W'({item_s1.rtt_sample_ms, 3'b000});
						rvar_x4_d = '0;
						rto_d     = clamp_rto(RTO_SUM_W'({item_s1.rtt_sample_ms, 2'b00})
						                      + RTO_PAD);
					end else begin
						srtt_x8_d = srtt_sum[SRTT_W-1:0];
						rvar_x4_d = rvar_sum[RVAR_W-1:0];
						rto_d     = clamp_rto(RTO_SUM_W'(srtt_sum[SRTT_W-1:3])
						                      + RTO_SUM_W'(rvar_sum[RVAR_W-1:0]) + RTO_PAD);
					end
					cwnd_d = (cwnd_grown > cwnd_cap) ? cwnd_cap[WIN_W-1:0]
					                                 : cwnd_grown[WIN_W-1:0];
				end
			end
			KIND_TIMEOUT: begin
				if (item_s1.window_cut_allowed) begin
					// Back off the timer and fall back to a two-packet window.
					rto_d      = clamp_rto(RTO_SUM_W'({rto_q, 1'b0}));
					ssthresh_d = (cwnd_half < TWO_PKT) ? TWO_PKT : cwnd_half;
					cwnd_d     = TWO_PKT;
				end
				give_up_d = item_s1.transmit_count > retry_limit_q;
			end
			KIND_RESTART: begin
				cwnd_d        = to_q(initial_window_q);
				ssthresh_d    = to_q(window_limit_q);
				peer_window_d = window_limit_q;
			end
			default: ;
		endcase

		// Sender may have no more in flight than either window allows.
		send_limit_d = (cwnd_d[WIN_W-1:FRAC_BITS] > peer_window_d) ? peer_window_d
		                                                           : cwnd_d[WIN_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_estimate_q <= 1'b0;
			srtt_x8_q      <= '0;
			rvar_x4_q      <= '0;
			rto_q          <= RTO_MAX;
			cwnd_q         <= to_q(INITIAL_WINDOW_RST);
			ssthresh_q     <= to_q(WINDOW_LIMIT_RST);
			peer_window_q  <= WINDOW_LIMIT_RST;
		end else if (advance) begin
			has_estimate_q <= has_estimate_d;
			srtt_x8_q      <= srtt_x8_d;
			rvar_x4_q      <= rvar_x4_d;
			rto_q          <= rto_d;
			cwnd_q         <= cwnd_d;
			ssthresh_q     <= ssthresh_d;
			peer_window_q  <= peer_window_d;
		end
	end

	// Valid flags of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
		if (advance) begin
			out_data_q.rto_ms      <= rto_d;
			out_data_q.cwnd_q8     <= cwnd_d;
			out_data_q.ssthresh_q8 <= ssthresh_d;
			out_data_q.send_limit  <= send_limit_d;
			out_data_q.give_up     <= give_up_d;
		end
	end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for the congestion-control core. Item beats are driven on the falling
// edge and every result beat is sampled on the rising edge. Each accepted item is
// run through a behavioural model of the estimator and window logic kept here;
// its result, or the typed-in one of a directed row, is queued, and each result
// beat from the block is checked field by field against the oldest queue entry.
module tb_top;
	import rrcw_pkg::*;

	// Item kind three has no member in the package enum, but the block still has
	// to treat it as a no-op. Register index three is unused and must be ignored.
	localparam logic [1:0]           KIND_IDLE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
	localparam int                   PHASES     = 10;
	localparam int                   PHASE_BEATS = 184;

	// A directed row holds the item beat and, where the answer is plain from the
	// reset state, the result typed in by hand. Every other row uses the model.
	typedef struct packed {
		item_t   beat;
		logic    typed;
		result_t want;
	} step_row_t;

	localparam result_t UNCHECKED = '0;

	// These rows run on the reset register values: initial window 2, window
	// limit 64 and retry limit 3.
	localparam step_row_t DIRECTED_STEPS [25] = '{
		// Unused kind three with every field set: nothing moves.
		'{'{KIND_IDLE, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 8'hFF}, 1'b1,
			'{13'd5000, 24'd512, 24'd16384, 16'd2, 1'b0}},
		// An ack with no sample only stores the receiver window, zero first.
		'{'{KIND_ACK, 16'hFFFF, 1'b0, 16'h0000, 1'b1, 8'hFF}, 1'b1,
			'{13'd5000, 24'd512, 24'd16384, 16'd0, 1'b0}},
		'{'{KIND_ACK, 16'h0000, 1'b0, 16'hFFFF, 1'b0, 8'h00}, 1'b1,
			'{13'd5000, 24'd512, 24'd16384, 16'd2, 1'b0}},
		// A timeout that may not cut the window leaves the state alone, but it
		// still reports give-up above the retry limit; the rows test either side.
		'{'{KIND_TIMEOUT, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 8'd255}, 1'b1,
			'{13'd5000, 24'd512, 24'd16384, 16'd2, 1'b1}},
		'{'{KIND_TIMEOUT, 16'h0000, 1'b0, 16'h0000, 1'b0, 8'd3}, 1'b1,
			'{13'd5000, 24'd512, 24'd16384, 16'd2, 1'b0}},
		'{'{KIND_TIMEOUT, 16'h0000, 1'b0, 16'h0000, 1'b0, 8'd4}, 1'b1,
			'{13'd5000, 24'd512, 24'd16384, 16'd2, 1'b1}},
		'{'{KIND_TIMEOUT, 16'h0000, 1'b0, 16'h0000, 1'b0, 8'd0}, 1'b1,
			'{13'd5000, 24'd512, 24'd16384, 16'd2, 1'b0}},
		// The first sample seeds the estimate. A zero RTT plus the pad is
		// clamped up to the minimum RTO, and slow start doubles cwnd.
		'{'{KIND_ACK, 16'h0000, 1'b1, 16'hFFFF, 1'b0, 8'h00}, 1'b1,
			'{13'd1000, 24'd1024, 24'd16384, 16'd4, 1'b0}},
		// Samples at full scale push the RTO up against its maximum.
		'{'{KIND_ACK, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 8'h00}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'hFFFF, 1'b1, 16'd3, 1'b0, 8'h00}, 1'b0, UNCHECKED},
		// Cuts: the second one halves a two-packet window, so ssthresh is held
		// at its two-packet floor.
		'{'{KIND_TIMEOUT, 16'h0000, 1'b0, 16'h0000, 1'b1, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_TIMEOUT, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 8'd255}, 1'b0, UNCHECKED},
		// A restart reloads the windows but keeps the RTT estimate.
		'{'{KIND_RESTART, 16'h1234, 1'b1, 16'h0042, 1'b1, 8'h5A}, 1'b0, UNCHECKED},
		// Slow start runs up to the window limit, and then holds there.
		'{'{KIND_ACK, 16'd100, 1'b1, 16'd100, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd120, 1'b1, 16'd100, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd80, 1'b1, 16'd100, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd200, 1'b1, 16'd100, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd100, 1'b1, 16'd100, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd100, 1'b1, 16'd100, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		// Cutting a full window puts ssthresh at half of it. Then slow start
		// climbs back up and goes over to additive increase.
		'{'{KIND_TIMEOUT, 16'd0, 1'b0, 16'd0, 1'b1, 8'd3}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd90, 1'b1, 16'd40, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd95, 1'b1, 16'd40, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd1, 1'b1, 16'd40, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd3000, 1'b1, 16'd40, 1'b0, 8'd0}, 1'b0, UNCHECKED},
		'{'{KIND_ACK, 16'd100, 1'b1, 16'd40, 1'b0, 8'd0}, 1'b0, UNCHECKED}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	rrcw_item_if   item_ch ();
	rrcw_result_if result_ch ();

	rtt_rto_congestion_window uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	// The model keeps its own copy of the registers and of the state. Wide signed
	// integers are used so that the RTT difference can go negative without any
	// trouble, and all the values stay well inside the block's field widths.
	logic [PKT_W-1:0]   cfg_init_win;
	logic [PKT_W-1:0]   cfg_win_limit;
	logic [RETRY_W-1:0] cfg_retry;
	bit                 est_valid;
	longint             srtt_x8;
	longint             rttvar_x4;
	longint             rto_now;
	longint             cwnd_now;
	longint             ssth_now;
	longint             peer_win;

	result_t pending_outcomes [$];
	bit      failed = 1'b0;
	// Once calm is set, neither side idles any more.
	bit      calm = 1'b0;
	int      stall_left = 0;
	int      flow_left = 0;

	function automatic longint clamp_timeout(longint r);
		if (r > longint'(RTO_MAX)) begin
			return longint'(RTO_MAX);
		end
		if (r < longint'(RTO_MIN)) begin
			return longint'(RTO_MIN);
		end
		return r;
	endfunction

	// Used at reset and on a restart beat.
	function automatic void load_windows_from_regs();
		cwnd_now = longint'(cfg_init_win) << FRAC_BITS;
		ssth_now = longint'(cfg_win_limit) << FRAC_BITS;
		peer_win = longint'(cfg_win_limit);
	endfunction

	// Apply one item to the model. The return value is the result beat that the
	// block should hand back for it.
	function automatic result_t advance_window_model(item_t it);
		result_t r;
		longint  rtt;
		longint  diff;
		longint  cap;
		longint  whole;
		r = '0;
		case (it.kind)
			KIND_ACK: begin
				peer_win = longint'(it.receiver_window);
				if (it.sample_valid) begin
					rtt = longint'(it.rtt_sample_ms);
					if (!est_valid) begin
						est_valid = 1'b1;
						srtt_x8   = rtt << 3;
						rttvar_x4 = 0;
						rto_now   = clamp_timeout((rtt << 2) + longint'(RTO_PAD));
					end else begin
						// Here srtt moves by an eighth of the error, and the
						// variance by a quarter of the change in its size.
						diff    = rtt - (srtt_x8 >>> 3);
						srtt_x8 = srtt_x8 + diff;
						if (diff < 0) begin
							diff = -diff;
						end
						rttvar_x4 = rttvar_x4 + diff - (rttvar_x4 >>> 2);
						rto_now   = clamp_timeout((srtt_x8 >>> 3) + rttvar_x4
							+ longint'(RTO_PAD));
					end
					if (cwnd_now < ssth_now) begin
						cwnd_now = cwnd_now * 2;
					end else begin
						cwnd_now = cwnd_now + longint'(ONE_PKT);
					end
					cap = longint'(cfg_win_limit) << FRAC_BITS;
					if (cwnd_now > cap) begin
						cwnd_now = cap;
					end
				end
			end
			KIND_TIMEOUT: begin
				if (it.window_cut_allowed) begin
					rto_now  = clamp_timeout(rto_now << 1);
					ssth_now = cwnd_now >>> 1;
					cwnd_now = longint'(TWO_PKT);
					if (ssth_now < longint'(TWO_PKT)) begin
						ssth_now = longint'(TWO_PKT);
					end
				end
				r.give_up = (it.transmit_count > cfg_retry);
			end
			KIND_RESTART: begin
				load_windows_from_regs();
			end
			default: begin
			end
		endcase
		whole = cwnd_now >>> FRAC_BITS;
		if (whole > peer_win) begin
			whole = peer_win;
		end
		r.rto_ms      = RTO_W'(rto_now);
		r.cwnd_q8     = WIN_W'(cwnd_now);
		r.ssthresh_q8 = WIN_W'(ssth_now);
		r.send_limit  = PKT_W'(whole);
		return r;
	endfunction

	// Random items follow the shape of real traffic: mostly acks that carry
	// RTT samples, then some timeouts, and now and then a restart or a no-op.
	// The fields that a given kind ignores are still filled at random.
	function automatic item_t random_beat();
		item_t it;
		int    pick;
		int    near;
		it.rtt_sample_ms      = 16'($urandom_range(50, 1500));
		it.sample_valid       = 1'($urandom_range(0, 1));
		it.receiver_window    = 16'($urandom_range(0, 300));
		it.window_cut_allowed = ($urandom_range(0, 3) != 0);
		it.transmit_count     = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: it.rtt_sample_ms = 16'($urandom_range(0, 65535));
			1: it.rtt_sample_ms = 16'($urandom_range(0, 50));
			default: begin
			end
		endcase
		if ($urandom_range(0, 3) == 0) begin
			it.receiver_window = 16'($urandom_range(0, 65535));
		end
		// Half of the transmit counts fall right next to the retry limit.
		if ($urandom_range(0, 1) == 0) begin
			near = int'(cfg_retry) + $urandom_range(0, 2) - 1;
			if (near < 0) begin
				near = 0;
			end else if (near > 255) begin
				near = 255;
			end
			it.transmit_count = 8'(near);
		end
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			it.kind         = KIND_ACK;
			it.sample_valid = 1'b1;
		end else if (pick < 65) begin
			it.kind         = KIND_ACK;
			it.sample_valid = 1'b0;
		end else if (pick < 88) begin
			it.kind = KIND_TIMEOUT;
		end else if (pick < 94) begin
			it.kind = KIND_RESTART;
		end else begin
			it.kind = KIND_IDLE;
		end
		return it;
	endfunction

	// Present one item beat and hold it until it is taken. At that same rising
	// edge, queue the expected result: the typed-in one where there is one,
	// otherwise the one from the model. The model is stepped in either case.
	task automatic send_beat(input item_t it, input bit typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do begin
			@(posedge clk);
		end while (item_ch.ready !== 1'b1);
		predicted = advance_window_model(it);
		pending_outcomes.insert(pending_outcomes.size(), typed ? want : predicted);
	endtask

	// Drop valid, and then wait until every queued result has come back.
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_INITIAL_WINDOW: cfg_init_win = val;
			REG_WINDOW_LIMIT:   cfg_win_limit = val;
			REG_RETRY_LIMIT:    cfg_retry = val[RETRY_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic compare_outcome(input result_t got, input result_t want);
		if (got.rto_ms !== want.rto_ms) begin
			$display("%0t: rto_ms expected %0d, got %0d", $time, want.rto_ms, got.rto_ms);
			failed = 1'b1;
		end
		if (got.cwnd_q8 !== want.cwnd_q8) begin
			$display("%0t: cwnd_q8 expected %0d, got %0d", $time, want.cwnd_q8, got.cwnd_q8);
			failed = 1'b1;
		end
		if (got.ssthresh_q8 !== want.ssthresh_q8) begin
			$display("%0t: ssthresh_q8 expected %0d, got %0d", $time, want.ssthresh_q8,
				got.ssthresh_q8);
			failed = 1'b1;
		end
		if (got.send_limit !== want.send_limit) begin
			$display("%0t: send_limit expected %0d, got %0d", $time, want.send_limit,
				got.send_limit);
			failed = 1'b1;
		end
		if (got.give_up !== want.give_up) begin
			$display("%0t: give_up expected %0d, got %0d", $time, want.give_up, got.give_up);
			failed = 1'b1;
		end
	endtask

	// The result side takes each beat at the rising edge. If a beat arrives while
	// nothing is queued, the block has produced a result that no item called for.
	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %p", $time,
					result_ch.data);
				failed = 1'b1;
			end else begin
				compare_outcome(result_ch.data, pending_outcomes[0]);
				pending_outcomes.delete(0);
			end
		end
	end

	// Back-pressure on the result side. Stalls and runs of free flow, each of
	// random length, follow one another at random, so that the stalls land on
	// every phase of the pipeline.
	always @(negedge clk) begin
		if (calm) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (flow_left > 0) begin
			result_ch.ready <= 1'b1;
			flow_left = flow_left - 1;
		end else if ($urandom_range(0, 1) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 14);
		end else begin
			result_ch.ready <= 1'b1;
			flow_left = $urandom_range(0, 39);
		end
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		wr_index        = REG_INITIAL_WINDOW;
		wr_data         = '0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;

		// Model state after reset: the registers hold their reset values and
		// the windows are loaded from them.
		cfg_init_win  = INITIAL_WINDOW_RST;
		cfg_win_limit = WINDOW_LIMIT_RST;
		cfg_retry     = RETRY_LIMIT_RST;
		est_valid     = 1'b0;
		srtt_x8       = 0;
		rttvar_x4     = 0;
		rto_now       = longint'(RTO_MAX);
		load_windows_from_regs();

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_STEPS[i]) begin
			send_beat(DIRECTED_STEPS[i].beat, DIRECTED_STEPS[i].typed,
				DIRECTED_STEPS[i].want);
		end

		// Each phase first drains the block, then writes all three registers,
		// then sends a restart so that the new windows take effect. The first
		// phases use the extremes of the registers and the later ones random
		// values. In the last phase neither side idles at all.
		for (int p = 0; p < PHASES; p++) begin
			logic [CFG_W-1:0] init_val;
			logic [CFG_W-1:0] limit_val;
			logic [CFG_W-1:0] retry_val;
			item_t            restart_beat;
			case (p)
				0: begin
					init_val  = 16'd1;
					limit_val = 16'd1;
					retry_val = 16'd0;
				end
				1: begin
					init_val  = 16'hFFFF;
					limit_val = 16'hFFFF;
					retry_val = 16'h00FF;
				end
				2: begin
					init_val  = 16'd1;
					limit_val = 16'hFFFF;
					retry_val = 16'd3;
				end
				3: begin
					init_val  = 16'hFFFF;
					limit_val = 16'd1;
					retry_val = 16'd128;
				end
				default: begin
					init_val  = 16'($urandom_range(1, 100));
					limit_val = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 65535))
						: 16'($urandom_range(1, 2000));
					retry_val = 16'($urandom_range(0, 255));
				end
			endcase
			// The upper byte of the retry write is random: only the low byte
			// should be kept.
			retry_val[CFG_W-1:RETRY_W] = RETRY_W'($urandom_range(0, 255));
			if (p == PHASES - 1) begin
				calm = 1'b1;
			end
			drain();
			write_reg(REG_INITIAL_WINDOW, init_val);
			write_reg(REG_WINDOW_LIMIT, limit_val);
			write_reg(REG_RETRY_LIMIT, retry_val);
			if (p == 4) begin
				// A write to the unused index must leave every register as it is.
				write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
			end
			restart_beat      = random_beat();
			restart_beat.kind = KIND_RESTART;
			send_beat(restart_beat, 1'b0, UNCHECKED);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				send_beat(random_beat(), 1'b0, UNCHECKED);
			end
		end

		drain();
		// Wait for any stray extra beats to show up.
		repeat (8) @(posedge clk);
		if (!failed) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- rtt_rto_congestion_window.f -----
rtl/rrcw_pkg.sv
rtl/rrcw_item_if.sv
rtl/rrcw_result_if.sv
rtl/rtt_rto_congestion_window.sv
test/tb_top.sv
